FILE: hdl/rms_pkg.sv
// Shared constants for the running mean square block.
package rms_pkg;

  // Configuration register widths and reset values
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned RECIP_W      = 33;
  localparam int unsigned CFG_DATA_W   = 33;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned LEN_RESET    = 64;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 33'd67108864;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RECIPROCAL = 1'b1;

  // Default build parameters
  localparam int unsigned DEF_MAX_WINDOW  = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  // Output queue depth; also bounds the words in flight
  localparam int unsigned FIFO_DEPTH = 8;

  // Reciprocal is split into a 32-bit low part and a one-bit high part
  localparam int unsigned RL_W = 32;

endpackage

FILE: hdl/rms_ring.sv
// Square ring memory with read-modify-write running sum update.
module rms_ring #(
  parameter int unsigned MAX_WINDOW  = rms_pkg::DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned POS_W = $clog2(MAX_WINDOW),
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1,
  localparam int unsigned SUM_W = SQ_W + POS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [POS_W:0]                eff_len_i,
  output logic                          sum_valid_o,
  output logic [SUM_W-1:0]              sum_o
);

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [POS_W:0]         fill_q, fill_d;
  logic [POS_W-1:0]       rd_pos;
  logic [POS_W:0]         next_pos;
  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] sq_full;
  logic [SQ_W-1:0]        sq;

  logic                   s1_valid_q;
  logic [POS_W-1:0]       s1_pos_q;
  logic [SQ_W-1:0]        s1_sq_q;
  logic                   s1_fwd_q;
  logic [SQ_W-1:0]        s1_fwd_data_q;
  logic                   s1_written_q;
  logic [SQ_W-1:0]        rdata_q;
  logic [SQ_W-1:0]        old_sq;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   sum_valid_q;

  logic [SQ_W-1:0]        ring_mem [MAX_WINDOW];

  // magnitude of the most negative sample still fits unsigned
  assign mag     = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
  assign sq_full = mag * mag;
  assign sq      = sq_full[SQ_W-1:0];

  always_comb begin
    rd_pos   = ({1'b0, pos_q} >= eff_len_i) ? '0 : pos_q;
    next_pos = {1'b0, rd_pos} + 1'b1;
    pos_d    = (next_pos >= eff_len_i) ? '0 : next_pos[POS_W-1:0];
    // writes run as a prefix from entry zero: count how far it reaches
    fill_d   = ({1'b0, rd_pos} == fill_q) ? fill_q + 1'b1 : fill_q;
  end

  always_comb begin
    if (s1_fwd_q) begin
      old_sq = s1_fwd_data_q;
    end else if (s1_written_q) begin
      old_sq = rdata_q;
    end else begin
      old_sq = '0;
    end
    sum_d = sum_q + SUM_W'(s1_sq_q) - SUM_W'(old_sq);
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdata_q <= ring_mem[rd_pos];
    end
    if (s1_valid_q) begin
      ring_mem[s1_pos_q] <= s1_sq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept_i;
      sum_valid_q <= s1_valid_q;
      if (accept_i) begin
        pos_q  <= pos_d;
        fill_q <= fill_d;
      end
      if (s1_valid_q) begin
        sum_q <= sum_d;
      end
    end
  end

  // payload of the read-modify-write stage
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pos_q      <= rd_pos;
      s1_sq_q       <= sq;
      s1_written_q  <= ({1'b0, rd_pos} < fill_q);
      // write of the previous word lands in the same cycle as this read
      s1_fwd_q      <= s1_valid_q && (s1_pos_q == rd_pos);
      s1_fwd_data_q <= s1_sq_q;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

FILE: hdl/rms_scale.sv
// Pipelined multiply of the window sum by the reciprocal, with saturation.
module rms_scale #(
  parameter int unsigned MAX_WINDOW  = rms_pkg::DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned POS_W  = $clog2(MAX_WINDOW),
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS - 1,
  localparam int unsigned SUM_W  = SQ_W + POS_W,
  localparam int unsigned H      = (SUM_W + 1) / 2,
  localparam int unsigned HI_W   = SUM_W - H,
  localparam int unsigned RL_W   = rms_pkg::RL_W,
  localparam int unsigned PROD_W = SUM_W + rms_pkg::RECIP_W,
  localparam int unsigned Q_W    = PROD_W - RL_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sum_valid_i,
  input  logic [SUM_W-1:0]            sum_i,
  input  logic [rms_pkg::RECIP_W-1:0] recip_i,
  output logic                        mean_valid_o,
  output logic [SQ_W-1:0]             mean_o
);

  localparam logic [Q_W-1:0] MEAN_MAX = Q_W'(1) << (SQ_W - 1);

  logic [H-1:0]        sl;
  logic [HI_W-1:0]     sh;
  logic [RL_W-1:0]     rl;

  logic                va_q, vb_q, vc_q;
  logic [H+RL_W-1:0]   plo_q;
  logic [HI_W+RL_W-1:0] phi_q;
  logic [SUM_W-1:0]    sum_a_q;
  logic                rh_q;
  logic [PROD_W-1:0]   total_d, total_q;
  logic [Q_W-1:0]      quot;
  logic [SQ_W-1:0]     mean_q;

  assign sl = sum_i[H-1:0];
  assign sh = sum_i[SUM_W-1:H];
  assign rl = recip_i[RL_W-1:0];

  always_comb begin
    total_d = PROD_W'(plo_q) + (PROD_W'(phi_q) << H);
    if (rh_q) begin
      total_d = total_d + (PROD_W'(sum_a_q) << RL_W);
    end
  end

  assign quot = total_q[PROD_W-1:RL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= sum_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i) begin
      plo_q   <= sl * rl;
      phi_q   <= sh * rl;
      sum_a_q <= sum_i;
      rh_q    <= recip_i[RL_W];
    end
    if (va_q) begin
      total_q <= total_d;
    end
    if (vb_q) begin
      mean_q <= (quot > MEAN_MAX) ? MEAN_MAX[SQ_W-1:0] : quot[SQ_W-1:0];
    end
  end

  assign mean_valid_o = vc_q;
  assign mean_o       = mean_q;

endmodule

FILE: hdl/rms_fifo.sv
// Output word queue with an in-flight credit count.
module rms_fifo #(
  parameter int unsigned DATA_W = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              reserve_i,
  output logic              has_room_o,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned DEPTH = rms_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  occ_q, pend_q;
  logic              pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (occ_q != '0);
  assign pop_data_o  = store_q[rd_ptr_q];
  assign has_room_o  = (pend_q < CNT_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      pend_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      occ_q  <= occ_q + CNT_W'(push_i) - CNT_W'(pop);
      pend_q <= pend_q + CNT_W'(reserve_i) - CNT_W'(pop);
    end
  end

endmodule

FILE: hdl/running_mean_square.sv
// An accepted word passes the ring, sum, product, total and mean registers, then the queue.
// Throughput: one sample word per cycle while credit remains; the ring memory read and
// write-back overlap, with the previous word's square forwarded when both touch the same entry.
// Up to eight words may be in flight; s_axis_tready drops when that credit is used.
// Reset: asynchronous, active low; the ring memory is not swept, a fill count
// marks entries never written since reset, which read as zero.
module running_mean_square #(
  parameter int unsigned MAX_WINDOW  = rms_pkg::DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned SQ_W       = 2 * SAMPLE_BITS - 1,
  localparam int unsigned IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W = ((SQ_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rms_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IN_DATA_W-1:0]             s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OUT_DATA_W-1:0]            m_axis_tdata    // [SQ_W-1:0] mean_square
);

  localparam int unsigned POS_W = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W = SQ_W + POS_W;
  localparam int unsigned CMP_W = (rms_pkg::LEN_W > POS_W + 1) ? rms_pkg::LEN_W : POS_W + 1;

  logic [rms_pkg::LEN_W-1:0]   window_length_q;
  logic [rms_pkg::RECIP_W-1:0] window_reciprocal_q;
  logic [CMP_W-1:0]            len_ext;
  logic [POS_W:0]              eff_len;
  logic                        accept;
  logic                        has_room;
  logic                        sum_valid;
  logic [SUM_W-1:0]            sum;
  logic                        mean_valid;
  logic [SQ_W-1:0]             mean;

  // Config registers; the user must write them only while the block is idle, it is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q     <= rms_pkg::LEN_W'(rms_pkg::LEN_RESET);
      window_reciprocal_q <= rms_pkg::RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rms_pkg::REG_WINDOW_LENGTH: begin
          window_length_q <= cfg_data_i[rms_pkg::LEN_W-1:0];
        end
        rms_pkg::REG_WINDOW_RECIPROCAL: begin
          window_reciprocal_q <= cfg_data_i[rms_pkg::RECIP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective window: zero means one, anything above the ring size saturates.
  always_comb begin
    len_ext = CMP_W'(window_length_q);
    if (len_ext == '0) begin
      eff_len = (POS_W + 1)'(1);
    end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = (POS_W + 1)'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[POS_W:0];
    end
  end

  // Take a word only while credit remains in the output queue.
  assign s_axis_tready = has_room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Square, ring read-modify-write and running sum.
  rms_ring #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .eff_len_i   (eff_len),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  // Sum times Q1.32 reciprocal, shift by 32, clamp to full scale.
  rms_scale #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_i        (sum),
    .recip_i      (window_reciprocal_q),
    .mean_valid_o (mean_valid),
    .mean_o       (mean)
  );

  // Output queue decouples a stalled consumer from the pipeline.
  rms_fifo #(
    .DATA_W (SQ_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (accept),
    .has_room_o  (has_room),
    .push_i      (mean_valid),
    .push_data_i (mean),
    .pop_valid_o (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .pop_data_o  (m_axis_tdata[SQ_W-1:0])
  );

  assign m_axis_tdata[OUT_DATA_W-1:SQ_W] = '0;

endmodule
